// File: src/frrs_pkg.sv
// Shared types and constants for the fault recovery retry sequencer.
package frrs_pkg;

    localparam int ATTEMPT_BITS = 8;
    localparam int DELAY_BITS   = 16;

    localparam int ACTION_BITS  = 3;
    localparam int MODE_BITS    = 3;

    // Packed port widths, rounded up to whole bytes.
    localparam int IN_DATA_BITS  = ((ATTEMPT_BITS + DELAY_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((MODE_BITS + 4 + ATTEMPT_BITS + 7) / 8) * 8;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_PAUSE   = 3'd0,
        ACT_RETRACT = 3'd1,
        ACT_RETRY   = 3'd2,
        ACT_CANCEL  = 3'd3,
        ACT_ESTOP   = 3'd4,
        ACT_TICK    = 3'd5
    } action_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_IDLE    = 3'd0,
        MODE_HOLDING = 3'd1,
        MODE_RETRACT = 3'd2,
        MODE_READY   = 3'd3,
        MODE_ESTOP   = 3'd4
    } mode_t;

    // One event beat as it sits in the input register.
    typedef struct packed {
        action_t                 action;
        logic [ATTEMPT_BITS-1:0] attempts;
        logic [DELAY_BITS-1:0]   delay_ticks;
        logic                    probe_ok;
    } item_t;

    // One status beat as it sits in the result register.
    typedef struct packed {
        mode_t                   mode;
        logic                    hold_active;
        logic                    retreat_done;
        logic                    retrying;
        logic                    attempt_fired;
        logic [ATTEMPT_BITS-1:0] attempt_number;
    } result_t;

endpackage

// File: src/frrs_in_stage.sv
// Input register that captures one event beat from the slave side.
module frrs_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  frrs_pkg::item_t in_item,
    input  logic           advance,
    output logic           item_valid,
    output frrs_pkg::item_t item
);
    import frrs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // The register takes a new beat when empty or when its beat moves on.
    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: src/frrs_core.sv
// Supervisor state and the next-state logic for one event.
module frrs_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  frrs_pkg::item_t   item,
    output frrs_pkg::result_t result
);
    import frrs_pkg::*;

    mode_t                   mode_reg;
    mode_t                   mode_next;
    logic                    hold_reg;
    logic                    hold_next;
    logic                    retreat_reg;
    logic                    retreat_next;
    logic                    retry_reg;
    logic                    retry_next;
    logic [ATTEMPT_BITS-1:0] attempt_count_reg;
    logic [ATTEMPT_BITS-1:0] attempt_count_next;
    logic [ATTEMPT_BITS-1:0] attempt_limit_reg;
    logic [ATTEMPT_BITS-1:0] attempt_limit_next;
    logic [DELAY_BITS-1:0]   wait_count_reg;
    logic [DELAY_BITS-1:0]   wait_count_next;
    logic [DELAY_BITS-1:0]   wait_limit_reg;
    logic [DELAY_BITS-1:0]   wait_limit_next;
    logic [DELAY_BITS-1:0]   wait_inc;
    logic                    fired;

    assign wait_inc = wait_count_reg + {{(DELAY_BITS-1){1'b0}}, 1'b1};

    // Next state for the event in the input register.
    always_comb
    begin
        mode_next          = mode_reg;
        hold_next          = hold_reg;
        retreat_next       = retreat_reg;
        retry_next         = retry_reg;
        attempt_count_next = attempt_count_reg;
        attempt_limit_next = attempt_limit_reg;
        wait_count_next    = wait_count_reg;
        wait_limit_next    = wait_limit_reg;
        fired              = 1'b0;
        case (item.action)
            ACT_PAUSE:
            begin
                hold_next    = 1'b1;
                retreat_next = 1'b0;
                mode_next    = MODE_HOLDING;
            end
            ACT_RETRACT:
            begin
                hold_next    = 1'b0;
                retreat_next = 1'b1;
                mode_next    = MODE_RETRACT;
            end
            ACT_RETRY:
            begin
                attempt_limit_next = item.attempts;
                wait_limit_next    = (item.delay_ticks == '0)
                                   ? {{(DELAY_BITS-1){1'b0}}, 1'b1} : item.delay_ticks;
                wait_count_next    = '0;
                mode_next          = MODE_HOLDING;
                // Zero attempts fails at once.
                if (item.attempts == '0)
                begin
                    retry_next         = 1'b0;
                    attempt_count_next = '0;
                end
                else
                begin
                    retry_next         = 1'b1;
                    attempt_count_next = {{(ATTEMPT_BITS-1){1'b0}}, 1'b1};
                end
            end
            ACT_CANCEL:
            begin
                retry_next = 1'b0;
            end
            ACT_ESTOP:
            begin
                retry_next   = 1'b0;
                hold_next    = 1'b0;
                retreat_next = 1'b0;
                mode_next    = MODE_ESTOP;
            end
            ACT_TICK:
            begin
                if (retry_reg)
                begin
                    wait_count_next = wait_inc;
                    if (wait_inc >= wait_limit_reg)
                    begin
                        fired = 1'b1;
                        if (item.probe_ok)
                        begin
                            hold_next    = 1'b0;
                            retreat_next = 1'b1;
                            retry_next   = 1'b0;
                            mode_next    = MODE_READY;
                        end
                        else if (attempt_count_reg >= attempt_limit_reg)
                        begin
                            retry_next = 1'b0;
                            mode_next  = MODE_HOLDING;
                        end
                        else
                        begin
                            attempt_count_next = attempt_count_reg
                                               + {{(ATTEMPT_BITS-1){1'b0}}, 1'b1};
                            wait_count_next    = '0;
                        end
                    end
                end
            end
            default:
            begin
                // Unused action codes leave the state alone.
            end
        endcase
    end

    // State advances only when the event moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_IDLE;
            hold_reg          <= 1'b0;
            retreat_reg       <= 1'b0;
            retry_reg         <= 1'b0;
            attempt_count_reg <= '0;
            attempt_limit_reg <= '0;
            wait_count_reg    <= '0;
            wait_limit_reg    <= '0;
        end
        else if (advance)
        begin
            mode_reg          <= mode_next;
            hold_reg          <= hold_next;
            retreat_reg       <= retreat_next;
            retry_reg         <= retry_next;
            attempt_count_reg <= attempt_count_next;
            attempt_limit_reg <= attempt_limit_next;
            wait_count_reg    <= wait_count_next;
            wait_limit_reg    <= wait_limit_next;
        end
    end

    // The status beat reports the state after this event.
    always_comb
    begin
        result.mode           = mode_next;
        result.hold_active    = hold_next;
        result.retreat_done   = retreat_next;
        result.retrying       = retry_next;
        result.attempt_fired  = fired;
        result.attempt_number = attempt_count_next;
    end

endmodule

// File: src/frrs_out_stage.sv
// Result register that holds one status beat for the master side.
module frrs_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  frrs_pkg::result_t result_in,
    output logic              out_valid,
    input  logic              out_ready,
    output frrs_pkg::result_t result_out
);
    import frrs_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // A new beat replaces the old one as it leaves, or fills an empty register.
    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

// File: src/fault_recovery_retry_sequencer.sv
// Top level of the fault recovery retry sequencer.
//
// Event beats enter on the s_axis channel: tuser carries the action code
// (pause, retract, start retry, cancel, estop, tick), tdata the retry
// parameters and the probe answer. Every event gives exactly one status
// beat on the m_axis channel with the mode, flags and attempt number.
// An event waits in the input register; the next-state logic
// between that register and the result register updates the supervisor
// state as the beat moves on into the result register. One event is
// accepted in every cycle while m_axis_tready stays high; the rate is set
// by the single pass through the input register, state update and result
// register. When the receiver stalls, the result register holds its beat
// and the input register keeps one more event, after which s_axis_tready
// drops until the stall clears. Reset empties both registers and returns
// the supervisor to idle with no retry, zero counts and both flags low.
module fault_recovery_retry_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // attempts [7:0], delay_ticks [23:8], probe_ok [24], zero fill [31:25]
    input  logic [frrs_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // action [2:0]
    input  logic [frrs_pkg::ACTION_BITS-1:0]   s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mode [2:0], hold_active [3], retreat_done [4], retrying [5],
    // attempt_fired [6], attempt_number [14:7], zero fill [15]
    output logic [frrs_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
    import frrs_pkg::*;

    localparam int OUT_USED = MODE_BITS + 4 + ATTEMPT_BITS;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t core_result;
    result_t out_result;

    // Unpack the input beat.
    assign in_item.action      = action_t'(s_axis_tuser);
    assign in_item.attempts    = s_axis_tdata[ATTEMPT_BITS-1:0];
    assign in_item.delay_ticks = s_axis_tdata[ATTEMPT_BITS +: DELAY_BITS];
    assign in_item.probe_ok    = s_axis_tdata[ATTEMPT_BITS + DELAY_BITS];

    // An event moves on when the result register is free or being emptied.
    assign advance = item_valid && (!m_axis_tvalid || m_axis_tready);

    frrs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    frrs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (core_result)
    );

    frrs_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .result_in  (core_result),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .result_out (out_result)
    );

    // Pack the output beat.
    assign m_axis_tdata = {{(OUT_DATA_BITS-OUT_USED){1'b0}},
                           out_result.attempt_number,
                           out_result.attempt_fired,
                           out_result.retrying,
                           out_result.retreat_done,
                           out_result.hold_active,
                           out_result.mode};

    // A running retry always has a nonzero attempt number.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_result.retrying |-> out_result.attempt_number != '0)
        else $error("retry active with attempt number zero");

    // The estop mode leaves no flag and no retry behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_result.mode == MODE_ESTOP
        |-> !out_result.hold_active && !out_result.retreat_done && !out_result.retrying)
        else $error("estop mode with flags or retry still set");

    // A fired attempt always ends or continues a retry, never leaves estop or idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_result.attempt_fired
        |-> out_result.mode != MODE_ESTOP && out_result.mode != MODE_IDLE)
        else $error("attempt fired in estop or idle mode");

    // A beat moving on always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("status beat lost after advancing");

    // An accepted event beat sits in the input register in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> item_valid)
        else $error("accepted event beat not held");

endmodule
